// File: design/crd_pkg.sv
// Shared types, constants and a decode function for the channel record decoder.
package crd_pkg;

  localparam int unsigned FREQ_DIGITS  = 8;
  localparam int unsigned DCS_ROM_SIZE = 104;
  localparam int unsigned DCS_IDX_W    = $clog2(DCS_ROM_SIZE);

  localparam logic [15:0] TONE_OFF_ALT   = 16'hFFFF;
  localparam logic [15:0] TONE_CTCSS_MIN = 16'h0258;
  localparam logic [15:0] TONE_INV_BASE  = 16'h006A;
  localparam logic [15:0] TONE_NORM_LAST = 16'h0068;
  localparam logic [15:0] TONE_INV_LAST  = 16'h00D1;

  localparam logic [31:0] FREQ_ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [2:0] KIND_OFF     = 3'd0;
  localparam logic [2:0] KIND_CTCSS   = 3'd1;
  localparam logic [2:0] KIND_DCS_NRM = 3'd2;
  localparam logic [2:0] KIND_DCS_INV = 3'd3;
  localparam logic [2:0] KIND_INVALID = 3'd4;

  typedef struct packed {
    logic [31:0] rx_freq_bcd;
    logic [31:0] tx_freq_bcd;
    logic [15:0] rx_tone_code;
    logic [15:0] tx_tone_code;
    logic [7:0]  scan_code_byte;
    logic [7:0]  power_byte;
    logic [7:0]  option_byte;
  } crd_in_t;

  typedef struct packed {
    logic [30:0] rx_hz;
    logic [30:0] tx_hz;
    logic [2:0]  rx_tone_kind;
    logic [15:0] rx_tone_value;
    logic [2:0]  tx_tone_kind;
    logic [15:0] tx_tone_value;
    logic        low_power;
    logic        wide;
    logic        busy_lockout;
    logic        scan_add;
    logic [1:0]  ptt_id_mode;
    logic [3:0]  scan_code;
  } crd_out_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
  } crd_tone_t;

  localparam logic [30:0] FREQ_WEIGHT [FREQ_DIGITS] = '{
    31'd10, 31'd100, 31'd1000, 31'd10000,
    31'd100000, 31'd1000000, 31'd10000000, 31'd100000000
  };

  localparam logic [9:0] DCS_ROM [DCS_ROM_SIZE] = '{
    10'd23,  10'd25,  10'd26,  10'd31,  10'd32,  10'd36,  10'd43,  10'd47,
    10'd51,  10'd53,  10'd54,  10'd65,  10'd71,  10'd72,  10'd73,  10'd74,
    10'd114, 10'd115, 10'd116, 10'd122, 10'd125, 10'd131, 10'd132, 10'd134,
    10'd143, 10'd145, 10'd152, 10'd155, 10'd156, 10'd162, 10'd165, 10'd172,
    10'd174, 10'd205, 10'd212, 10'd223, 10'd225, 10'd226, 10'd243, 10'd244,
    10'd245, 10'd246, 10'd251, 10'd252, 10'd255, 10'd261, 10'd263, 10'd265,
    10'd266, 10'd271, 10'd274, 10'd306, 10'd311, 10'd315, 10'd325, 10'd331,
    10'd332, 10'd343, 10'd346, 10'd351, 10'd356, 10'd364, 10'd365, 10'd371,
    10'd411, 10'd412, 10'd413, 10'd423, 10'd431, 10'd432, 10'd445, 10'd446,
    10'd452, 10'd454, 10'd455, 10'd462, 10'd464, 10'd465, 10'd466, 10'd503,
    10'd506, 10'd516, 10'd523, 10'd526, 10'd532, 10'd546, 10'd565, 10'd606,
    10'd612, 10'd624, 10'd627, 10'd631, 10'd632, 10'd654, 10'd662, 10'd664,
    10'd703, 10'd712, 10'd723, 10'd731, 10'd732, 10'd734, 10'd743, 10'd754
  };

  // weight each nibble as it stands, digits above nine included
  function automatic logic [30:0] digits_to_hz(input logic [31:0] bcd);
    logic [30:0] sum;
    sum = '0;
    for (int k = 0; k < FREQ_DIGITS; k++) begin
      sum = sum + 31'(bcd[4*k +: 4]) * FREQ_WEIGHT[k];
    end
    return sum;
  endfunction

endpackage

// File: design/channel_record_decoder.sv
// Top level of the channel record decoder: input register, decode, result register.
//
// One stored channel record enters on the in_ channel as a request and one
// decoded result leaves on the out_ channel. Both channels use valid and
// stall; a request moves at a rising edge where valid is high and stall low.
// A request passes the input register, then the result register, before its
// result is shown on out_valid and out_data. Throughput: one request per
// cycle while out_stall does not hold the pipeline, set by the single decode
// pass between the two registers.
// When the receiver stalls with a result waiting, both registers hold and
// in_stall rises in the same cycle, so nothing is lost or repeated; the
// pipeline advances again as soon as out_stall falls.
// A receive frequency of all zeros or all ones gives an all-zero result.
// Reset (rst_n low, synchronous) empties both stages and holds in_stall high;
// no request is taken and out_valid stays low until the first request after reset.
module channel_record_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  crd_pkg::crd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output crd_pkg::crd_out_t out_data
);

  logic              adv;
  logic              s1_vld_r;
  crd_pkg::crd_in_t  s1_r;
  logic              out_vld_r;
  crd_pkg::crd_out_t out_r;
  crd_pkg::crd_out_t out_nxt;
  crd_pkg::crd_tone_t rx_tone;
  crd_pkg::crd_tone_t tx_tone;
  logic              disabled;

  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv || !rst_n;

  crd_tone_dec u_rx_tone (
    .code (s1_r.rx_tone_code),
    .tone (rx_tone)
  );

  crd_tone_dec u_tx_tone (
    .code (s1_r.tx_tone_code),
    .tone (tx_tone)
  );

  assign disabled = (s1_r.rx_freq_bcd == 32'd0) ||
                    (s1_r.rx_freq_bcd == crd_pkg::FREQ_ALL_ONES);

  always_comb begin
    out_nxt = '0;
    if (!disabled) begin
      out_nxt.rx_hz         = crd_pkg::digits_to_hz(s1_r.rx_freq_bcd);
      out_nxt.tx_hz         = crd_pkg::digits_to_hz(s1_r.tx_freq_bcd);
      out_nxt.rx_tone_kind  = rx_tone.kind;
      out_nxt.rx_tone_value = rx_tone.value;
      out_nxt.tx_tone_kind  = tx_tone.kind;
      out_nxt.tx_tone_value = tx_tone.value;
      out_nxt.low_power     = s1_r.power_byte[0];
      out_nxt.wide          = s1_r.option_byte[6];
      out_nxt.busy_lockout  = s1_r.option_byte[3];
      out_nxt.scan_add      = s1_r.option_byte[2];
      out_nxt.ptt_id_mode   = s1_r.option_byte[1:0];
      out_nxt.scan_code     = s1_r.scan_code_byte[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_valid;
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= in_data;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: design/crd_tone_dec.sv
// Squelch code word decoder: off, CTCSS, DCS normal or inverted, invalid index.
module crd_tone_dec (
  input  logic [15:0]       code,
  output crd_pkg::crd_tone_t tone
);

  logic [15:0]                   nrm_off;
  logic [15:0]                   inv_off;
  logic [crd_pkg::DCS_IDX_W-1:0] idx;
  logic                          use_inv;

  assign nrm_off = code - 16'd1;
  assign inv_off = code - crd_pkg::TONE_INV_BASE;
  assign use_inv = (code >= crd_pkg::TONE_INV_BASE);
  assign idx     = use_inv ? inv_off[crd_pkg::DCS_IDX_W-1:0]
                           : nrm_off[crd_pkg::DCS_IDX_W-1:0];

  always_comb begin
    tone.kind  = crd_pkg::KIND_OFF;
    tone.value = '0;
    if (code == 16'd0 || code == crd_pkg::TONE_OFF_ALT) begin
      tone.kind = crd_pkg::KIND_OFF;
    end else if (code >= crd_pkg::TONE_CTCSS_MIN) begin
      tone.kind  = crd_pkg::KIND_CTCSS;
      tone.value = code;
    end else if (!use_inv) begin
      if (code <= crd_pkg::TONE_NORM_LAST) begin
        tone.kind  = crd_pkg::KIND_DCS_NRM;
        tone.value = 16'(crd_pkg::DCS_ROM[idx]);
      end else begin
        tone.kind = crd_pkg::KIND_INVALID;
      end
    end else if (code <= crd_pkg::TONE_INV_LAST) begin
      tone.kind  = crd_pkg::KIND_DCS_INV;
      tone.value = 16'(crd_pkg::DCS_ROM[idx]);
    end else begin
      tone.kind = crd_pkg::KIND_INVALID;
    end
  end

endmodule
